FILE: rtl/wsd_pkg.sv
// ---------------------------------------------------------------------------
// wsd_pkg
// Shared constants, types, ring-index helpers and the velocity magnitude helper of the standstill detector.
// ---------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

    localparam int HISTORY_DEPTH = 64;
    localparam int IDX_W         = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int TIME_W        = 48;
    localparam int VEL_W         = 32;
    localparam int STOP_W        = 32;
    localparam int WIN_W         = 32;
    localparam int THR_W         = 64;
    localparam int SQ_W          = 2 * VEL_W;
    localparam int ENTRY_W       = TIME_W + 1;   // {moving, stamp}
    localparam int APB_AW        = 4;
    localparam int APB_DW        = 64;

    // register index, taken from paddr[3]
    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_THRESH = 1'b1;

    // item opcodes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic [IDX_W-1:0] slot_t;
    typedef logic [CNT_W-1:0] count_t;

    // next ring slot
    function automatic slot_t slot_inc(input slot_t a);
        slot_t r;
        if (a == slot_t'(HISTORY_DEPTH - 1))
            r = '0;
        else
            r = a + slot_t'(1);
        return r;
    endfunction

    // slot that lies b entries before slot a, b in 0..HISTORY_DEPTH
    function automatic slot_t slot_sub(input slot_t a, input count_t b);
        logic [CNT_W:0] wide;
        if ({1'b0, count_t'(a)} >= {1'b0, b})
            wide = {1'b0, count_t'(a)} - {1'b0, b};
        else
            wide = {1'b0, count_t'(a)} + (CNT_W+1)'(HISTORY_DEPTH) - {1'b0, b};
        return wide[IDX_W-1:0];
    endfunction

    // magnitude of a two's complement velocity
    function automatic logic [VEL_W-1:0] vel_mag(input logic [VEL_W-1:0] v);
        logic [VEL_W-1:0] r;
        if (v[VEL_W-1])
            r = ~v + VEL_W'(1);
        else
            r = v;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/wsd_ram.sv
// ---------------------------------------------------------------------------
// wsd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module wsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/windowed_standstill_detector.sv
// ---------------------------------------------------------------------------
// windowed_standstill_detector
// Time-windowed history of velocity samples with a standstill query.
// ---------------------------------------------------------------------------
//  channel   dir   handshake                 payload
//  s_axis    in    tvalid/tready             tdata: times, velocities; tuser: op
//  m_axis    out   tvalid/tready             tdata: stopped
//  apb       in    psel/penable/pready       window_length, still_threshold_sq
//
//  Add: 3 squares on one shared 32x32 multiplier, accumulate, write and
//  oldest read, then an aging pass that checks the oldest entries one by
//  one (none when only the newest entry is left).
//  Query: straight to the result on an empty history; else read and check
//  the oldest entry, start the walk, walk the history entries (up to 64) one
//  at a time through the single read port of the history RAM, then result.
//  Reset clears the history (empty) and loads the register defaults.
//  s_axis_tready is high only while the sequencer is idle; a finished
//  result waits in the output register while the next item is accepted,
//  and the result cycle stalls while that register is still full.
// ---------------------------------------------------------------------------
`default_nettype none

module windowed_standstill_detector (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // stream in
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // [47:0] now_time, [95:48] sample_time, [127:96] vel_x,
    // [159:128] vel_y, [191:160] vel_z, [223:192] stop_time
    input  wire logic [223:0]                s_axis_tdata,
    // [0] op
    input  wire logic [0:0]                  s_axis_tuser,
    // stream out
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // [0] stopped, [7:1] zero
    output logic [7:0]                       m_axis_tdata,
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [wsd_pkg::APB_AW-1:0]  paddr,
    input  wire logic [wsd_pkg::APB_DW-1:0]  pwdata,
    output logic      [wsd_pkg::APB_DW-1:0]  prdata,
    output logic                             pready
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_MUL      = 4'd1;
    localparam logic [3:0] ST_WR       = 4'd2;
    localparam logic [3:0] ST_DROP_RD  = 4'd3;
    localparam logic [3:0] ST_DROP     = 4'd4;
    localparam logic [3:0] ST_Q_OLD_RD = 4'd5;
    localparam logic [3:0] ST_Q_OLD    = 4'd6;
    localparam logic [3:0] ST_WALK_RD  = 4'd7;
    localparam logic [3:0] ST_WALK     = 4'd8;
    localparam logic [3:0] ST_RESULT   = 4'd9;

    localparam int TW = wsd_pkg::TIME_W;
    localparam int VW = wsd_pkg::VEL_W;

    logic [3:0]                   state_reg, state_next;
    logic                         op_reg;
    logic [TW-1:0]                now_reg, sample_reg;
    logic [VW-1:0]                vx_reg, vy_reg, vz_reg;
    logic [wsd_pkg::STOP_W-1:0]   stop_reg;
    logic [1:0]                   mul_cnt_reg;
    logic [wsd_pkg::SQ_W-1:0]     prod_reg;
    logic [wsd_pkg::THR_W-1:0]    sum_reg;
    wsd_pkg::slot_t               newest_reg, newest_next;
    wsd_pkg::count_t              count_reg, count_next;
    wsd_pkg::slot_t               walk_reg, walk_next;
    logic                         res_reg, res_next;
    logic                         out_valid_reg;
    logic                         out_stopped_reg;
    logic [wsd_pkg::WIN_W-1:0]    window_reg;
    logic [wsd_pkg::THR_W-1:0]    thresh_reg;

    logic                         in_acc;
    logic                         cfg_wr;
    logic [VW-1:0]                mag;
    logic                         ram_we;
    wsd_pkg::slot_t               ram_waddr, ram_raddr;
    logic [wsd_pkg::ENTRY_W-1:0]  ram_wdata, ram_rdata;
    logic [TW:0]                  age_diff;
    logic [wsd_pkg::STOP_W-1:0]   age_lim;
    logic                         age_gt, age_ge;
    logic                         moving;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_stopped_reg};

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[3])
            wsd_pkg::REG_WINDOW: prdata = {32'd0, window_reg};
            wsd_pkg::REG_THRESH: prdata = thresh_reg;
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= wsd_pkg::WIN_W'(1000000);
            thresh_reg <= wsd_pkg::THR_W'(1000000);
        end
        else if (cfg_wr)
        begin
            if (paddr[3] == wsd_pkg::REG_WINDOW)
                window_reg <= pwdata[wsd_pkg::WIN_W-1:0];
            else
                thresh_reg <= pwdata;
        end
    end

    // ---------------- history RAM ----------------
    wsd_ram #(
        .WIDTH (wsd_pkg::ENTRY_W),
        .DEPTH (wsd_pkg::HISTORY_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sum of squares is at most 3*2^62 and never saturates
    assign moving    = (sum_reg >= thresh_reg);
    assign ram_we    = (state_reg == ST_WR);
    assign ram_waddr = wsd_pkg::slot_inc(newest_reg);
    assign ram_wdata = {moving, sample_reg};

    always_comb
    begin
        case (state_reg)
            ST_DROP_RD:  ram_raddr = wsd_pkg::slot_sub(newest_reg,
                                                       count_reg - wsd_pkg::count_t'(1));
            // next-oldest entry, read ahead in case this one is dropped
            ST_DROP:     ram_raddr = wsd_pkg::slot_sub(newest_reg,
                                                       count_reg - wsd_pkg::count_t'(2));
            ST_Q_OLD_RD: ram_raddr = wsd_pkg::slot_sub(newest_reg,
                                                       count_reg - wsd_pkg::count_t'(1));
            ST_WALK:     ram_raddr = wsd_pkg::slot_sub(newest_reg,
                                     wsd_pkg::count_t'(walk_reg) + wsd_pkg::count_t'(1));
            default:     ram_raddr = newest_reg;
        endcase
    end

    // shared age compare: signed age = now - stamp
    assign age_diff = {1'b0, now_reg} - {1'b0, ram_rdata[TW-1:0]};
    assign age_lim  = (op_reg == wsd_pkg::OP_QUERY) ? stop_reg : window_reg;
    assign age_gt   = !age_diff[TW] && (age_diff[TW-1:0] >  TW'(age_lim));
    assign age_ge   = !age_diff[TW] && (age_diff[TW-1:0] >= TW'(age_lim));

    // ---------------- shared multiplier ----------------
    always_comb
    begin
        case (mul_cnt_reg)
            2'd0:    mag = wsd_pkg::vel_mag(vx_reg);
            2'd1:    mag = wsd_pkg::vel_mag(vy_reg);
            default: mag = wsd_pkg::vel_mag(vz_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg     <= s_axis_tuser[0];
            now_reg    <= s_axis_tdata[47:0];
            sample_reg <= s_axis_tdata[95:48];
            vx_reg     <= s_axis_tdata[127:96];
            vy_reg     <= s_axis_tdata[159:128];
            vz_reg     <= s_axis_tdata[191:160];
            stop_reg   <= s_axis_tdata[223:192];
            sum_reg    <= '0;
        end
        else if (state_reg == ST_MUL)
        begin
            if (mul_cnt_reg != 2'd3)
                prod_reg <= {32'd0, mag} * {32'd0, mag};
            if (mul_cnt_reg != 2'd0)
                sum_reg <= sum_reg + prod_reg;
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next  = state_reg;
        newest_next = newest_reg;
        count_next  = count_reg;
        walk_next   = walk_reg;
        res_next    = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_axis_tuser[0] == wsd_pkg::OP_ADD)
                        state_next = ST_MUL;
                    else if (count_reg == '0)
                    begin
                        res_next   = 1'b0;
                        state_next = ST_RESULT;
                    end
                    else
                        state_next = ST_Q_OLD_RD;
                end
            end
            ST_MUL:
            begin
                if (mul_cnt_reg == 2'd3)
                    state_next = ST_WR;
            end
            ST_WR:
            begin
                newest_next = wsd_pkg::slot_inc(newest_reg);
                // a full ring loses its oldest entry
                if (count_reg >= wsd_pkg::count_t'(wsd_pkg::HISTORY_DEPTH))
                    count_next = wsd_pkg::count_t'(wsd_pkg::HISTORY_DEPTH);
                else
                    count_next = count_reg + wsd_pkg::count_t'(1);
                state_next = ST_DROP_RD;
            end
            ST_DROP_RD:
            begin
                if (count_reg > wsd_pkg::count_t'(1))
                    state_next = ST_DROP;
                else
                    state_next = ST_IDLE;
            end
            ST_DROP:
            begin
                if (age_gt)
                begin
                    count_next = count_reg - wsd_pkg::count_t'(1);
                    if (count_reg <= wsd_pkg::count_t'(2))
                        state_next = ST_IDLE;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_Q_OLD_RD:
            begin
                state_next = ST_Q_OLD;
            end
            ST_Q_OLD:
            begin
                if (!age_ge)
                begin
                    res_next   = 1'b0;
                    state_next = ST_RESULT;
                end
                else
                    state_next = ST_WALK_RD;
            end
            ST_WALK_RD:
            begin
                walk_next  = '0;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                // the oldest entry is old enough, so the walk ends there at the latest
                if (ram_rdata[TW])
                begin
                    res_next   = 1'b0;
                    state_next = ST_RESULT;
                end
                else if (age_ge)
                begin
                    res_next   = 1'b1;
                    state_next = ST_RESULT;
                end
                else
                    walk_next = walk_reg + wsd_pkg::slot_t'(1);
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || m_axis_tready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            mul_cnt_reg     <= '0;
            newest_reg      <= '0;
            count_reg       <= '0;
            walk_reg        <= '0;
            res_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_stopped_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            newest_reg <= newest_next;
            count_reg  <= count_next;
            walk_reg   <= walk_next;
            res_reg    <= res_next;
            if (in_acc)
                mul_cnt_reg <= '0;
            else if (state_reg == ST_MUL)
                mul_cnt_reg <= mul_cnt_reg + 2'd1;
            if (state_reg == ST_RESULT && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_reg   <= 1'b1;
                out_stopped_reg <= res_reg;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

`ifndef NO_ASSERTIONS
    a_out_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_RESULT)
        else $error("result appeared outside the result state");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= wsd_pkg::count_t'(wsd_pkg::HISTORY_DEPTH))
        else $error("history count above ring depth");

    a_add_keeps_newest: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WR |=> count_reg != '0 && state_reg == ST_DROP_RD)
        else $error("add left history empty");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> wsd_pkg::count_t'(walk_reg) < count_reg)
        else $error("walk ran past oldest entry");
`endif

endmodule

`default_nettype wire
